// ----- hw/rtl/tli_pkg.sv -----
package tli_pkg;

  localparam int DATA_W     = 32;
  localparam int MAX_POINTS = 64;
  localparam int PTR_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = 7;
  localparam int PROD_W     = 2 * DATA_W;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  typedef struct packed {
    logic [DATA_W-1:0] num_a;
    logic [DATA_W-1:0] num_b;
    logic [DATA_W-1:0] den;
  } md_req_t;

endpackage

// ----- hw/rtl/table_linear_interpolator.sv -----
// Piecewise linear interpolator over a table of up to 64 (x, y) points in signed
// Q16.16, held in two RAMs with one write and one read port each. A word with
// func 0 writes one point; a word with func 1 is a query and returns one result.
// A query scans segments one per cycle from segment 0 over the x RAM, reads the
// two y points, then runs a bit-serial 32x32 multiply and a restoring 64-bit
// divide; on a zero-width segment the multiply and divide are skipped. Queries
// are handled one at a time; a finished result waits in the output register
// while the next word is accepted.
module table_linear_interpolator import tli_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_func,
  input  logic [PTR_W-1:0]         in_point_index,
  input  logic signed [DATA_W-1:0] in_point_x,
  input  logic signed [DATA_W-1:0] in_point_y,
  input  logic signed [DATA_W-1:0] in_query_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] out_interp_value,
  output logic [PTR_W-1:0]         out_segment_index,
  output logic [1:0]               out_status,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CNT_W-1:0]         cfg_point_count
);

  typedef enum logic [2:0] {S_IDLE, S_RD0, S_SCAN, S_Y0, S_Y1, S_MD, S_OUT} state_t;

  localparam logic signed [DATA_W+2:0] RES_MAX = (DATA_W+3)'((64'sd1 <<< (DATA_W-1)) - 1);
  localparam logic signed [DATA_W+2:0] RES_MIN = (DATA_W+3)'(-(64'sd1 <<< (DATA_W-1)));

  logic signed [DATA_W-1:0] x_mem [MAX_POINTS];
  logic signed [DATA_W-1:0] y_mem [MAX_POINTS];
  logic signed [DATA_W-1:0] x_rdata;
  logic signed [DATA_W-1:0] y_rdata;
  logic [PTR_W-1:0]         x_raddr;
  logic [PTR_W-1:0]         y_raddr;

  state_t                   state_r;
  logic [CNT_W-1:0]         point_count_r;
  logic [CNT_W-1:0]         n_use;
  logic [PTR_W-1:0]         i_r;
  logic signed [DATA_W-1:0] v_r;
  logic signed [DATA_W-1:0] x0_r;
  logic signed [DATA_W-1:0] x1_r;
  logic signed [DATA_W-1:0] y0_r;
  logic                     neg_r;
  logic signed [DATA_W-1:0] res_r;
  logic [1:0]               res_st_r;

  logic                     out_valid_r;
  logic signed [DATA_W-1:0] out_value_r;
  logic [PTR_W-1:0]         out_seg_r;
  logic [1:0]               out_st_r;

  logic                     wr_acc;
  logic                     q_acc;
  logic                     hit;
  logic                     last_seg;
  logic [CNT_W-1:0]         i_plus2;
  logic signed [DATA_W:0]   dx;
  logic signed [DATA_W:0]   dy;
  logic signed [DATA_W:0]   dv;
  logic [DATA_W:0]          dx_neg;
  logic [DATA_W:0]          dy_neg;
  logic [DATA_W:0]          dv_neg;
  md_req_t                  md_req;
  logic                     md_start;
  logic                     md_done;
  logic [PROD_W-1:0]        md_quot;
  logic                     q_big;
  logic signed [DATA_W+2:0] y0_ext;
  logic signed [DATA_W+2:0] q_ext;
  logic signed [DATA_W+2:0] sum;
  logic                     out_load;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign wr_acc    = in_valid && in_ready && (in_func == FUNC_WRITE);
  assign q_acc     = in_valid && in_ready && (in_func == FUNC_QUERY);

  always_comb begin
    if (point_count_r < CNT_W'(2)) begin
      n_use = CNT_W'(2);
    end else if (point_count_r > CNT_W'(MAX_POINTS)) begin
      n_use = CNT_W'(MAX_POINTS);
    end else begin
      n_use = point_count_r;
    end
  end

  assign i_plus2  = {{(CNT_W-PTR_W){1'b0}}, i_r} + CNT_W'(2);
  assign hit      = ((x0_r <= v_r) && (v_r <= x_rdata)) || (v_r < x0_r);
  assign last_seg = i_plus2 >= n_use;

  always_comb begin
    x_raddr = '0;
    case (state_r)
      S_RD0:   x_raddr = PTR_W'(1);
      S_SCAN:  x_raddr = i_plus2[PTR_W-1:0];
      default: x_raddr = '0;
    endcase
  end

  assign y_raddr = (state_r == S_Y0) ? i_r + 1'b1 : i_r;

  always_ff @(posedge clk) begin
    if (wr_acc) begin
      x_mem[in_point_index] <= in_point_x;
      y_mem[in_point_index] <= in_point_y;
    end
    x_rdata <= x_mem[x_raddr];
    y_rdata <= y_mem[y_raddr];
  end

  assign dx     = 33'(x1_r) - 33'(x0_r);
  assign dy     = 33'(y_rdata) - 33'(y0_r);
  assign dv     = 33'(v_r) - 33'(x0_r);
  assign dx_neg = -dx;
  assign dy_neg = -dy;
  assign dv_neg = -dv;

  assign md_req.num_a = dy[DATA_W] ? dy_neg[DATA_W-1:0] : dy[DATA_W-1:0];
  assign md_req.num_b = dv[DATA_W] ? dv_neg[DATA_W-1:0] : dv[DATA_W-1:0];
  assign md_req.den   = dx[DATA_W] ? dx_neg[DATA_W-1:0] : dx[DATA_W-1:0];
  assign md_start     = (state_r == S_Y1) && (dx != '0);

  tli_muldiv u_muldiv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (md_start),
    .req   (md_req),
    .done  (md_done),
    .quot  (md_quot)
  );

  assign q_big  = (|md_quot[PROD_W-1:DATA_W+2]) ||
                  (md_quot[DATA_W+1] && (|md_quot[DATA_W:0]));
  assign y0_ext = (DATA_W+3)'(y0_r);
  assign q_ext  = $signed({1'b0, md_quot[DATA_W+1:0]});
  assign sum    = neg_r ? y0_ext - q_ext : y0_ext + q_ext;
  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      point_count_r <= CNT_W'(2);
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        point_count_r <= cfg_point_count;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (q_acc) begin
            v_r     <= in_query_value;
            state_r <= S_RD0;
          end
        end
        S_RD0: begin
          x0_r    <= x_rdata;
          i_r     <= '0;
          state_r <= S_SCAN;
        end
        S_SCAN: begin
          if (hit || last_seg) begin
            x1_r    <= x_rdata;
            state_r <= S_Y0;
          end else begin
            x0_r <= x_rdata;
            i_r  <= i_r + 1'b1;
          end
        end
        S_Y0: begin
          y0_r    <= y_rdata;
          state_r <= S_Y1;
        end
        S_Y1: begin
          neg_r <= dy[DATA_W] ^ dv[DATA_W] ^ dx[DATA_W];
          if (dx == '0) begin
            res_r    <= y0_r;
            res_st_r <= ST_ZERO;
            state_r  <= S_OUT;
          end else begin
            state_r <= S_MD;
          end
        end
        S_MD: begin
          if (md_done) begin
            state_r <= S_OUT;
            if (q_big) begin
              res_r    <= neg_r ? RES_MIN[DATA_W-1:0] : RES_MAX[DATA_W-1:0];
              res_st_r <= ST_SAT;
            end else if (sum > RES_MAX) begin
              res_r    <= RES_MAX[DATA_W-1:0];
              res_st_r <= ST_SAT;
            end else if (sum < RES_MIN) begin
              res_r    <= RES_MIN[DATA_W-1:0];
              res_st_r <= ST_SAT;
            end else begin
              res_r    <= sum[DATA_W-1:0];
              res_st_r <= ST_OK;
            end
          end
        end
        S_OUT: begin
          if (out_load) begin
            out_value_r <= res_r;
            out_seg_r   <= i_r;
            out_st_r    <= res_st_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_interp_value  = out_value_r;
  assign out_segment_index = out_seg_r;
  assign out_status        = out_st_r;

  a_done_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    md_done |-> (state_r == S_MD))
    else $error("divider finished outside wait state");

  a_scan_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (i_plus2 <= n_use))
    else $error("scan ran past last segment");

  a_zero_width: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && res_st_r == ST_ZERO) |-> (x0_r == x1_r))
    else $error("zero-width status on nonzero segment");

  a_out_from_fsm: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_OUT))
    else $error("result raised outside output state");

endmodule

// ----- hw/rtl/tli_muldiv.sv -----
module tli_muldiv import tli_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  md_req_t           req,
  output logic              done,
  output logic [PROD_W-1:0] quot
);

  typedef enum logic [1:0] {U_IDLE, U_MUL, U_ADD, U_DIV} ustate_t;

  ustate_t                  state_r;
  logic                     done_r;
  logic [$clog2(PROD_W)-1:0] cnt_r;
  logic [PROD_W-1:0]        acc_r;
  logic [PROD_W-1:0]        mcand_r;
  logic [DATA_W-1:0]        mplier_r;
  logic [DATA_W-1:0]        den_r;
  logic [DATA_W-1:0]        rem_r;
  logic [DATA_W:0]          trial;
  logic                     ge;
  logic [DATA_W:0]          diff;

  assign trial = {rem_r, acc_r[PROD_W-1]};
  assign ge    = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= U_IDLE;
      done_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        U_IDLE: begin
          if (start) begin
            mcand_r  <= {{(PROD_W-DATA_W){1'b0}}, req.num_a};
            mplier_r <= req.num_b;
            den_r    <= req.den;
            acc_r    <= '0;
            cnt_r    <= '0;
            state_r  <= U_MUL;
          end
        end
        U_MUL: begin
          if (mplier_r[0]) begin
            acc_r <= acc_r + mcand_r;
          end
          mcand_r  <= {mcand_r[PROD_W-2:0], 1'b0};
          mplier_r <= {1'b0, mplier_r[DATA_W-1:1]};
          cnt_r    <= cnt_r + 1'b1;
          if (cnt_r == $bits(cnt_r)'(DATA_W - 1)) begin
            state_r <= U_ADD;
          end
        end
        U_ADD: begin
          // bias by half the divisor for round to nearest
          acc_r   <= acc_r + {{(PROD_W-DATA_W+1){1'b0}}, den_r[DATA_W-1:1]};
          rem_r   <= '0;
          cnt_r   <= '0;
          state_r <= U_DIV;
        end
        U_DIV: begin
          rem_r <= ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
          acc_r <= {acc_r[PROD_W-2:0], ge};
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == $bits(cnt_r)'(PROD_W - 1)) begin
            done_r  <= 1'b1;
            state_r <= U_IDLE;
          end
        end
        default: state_r <= U_IDLE;
      endcase
    end
  end

  assign done = done_r;
  assign quot = acc_r;

endmodule
